// File: src/u2c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_pkg
// Shared types, constants and the code point map of the UTF-8 to CP1251
// converter.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int QueueDepth = 2;

  localparam logic [7:0]  UnknownChar = 8'h3F;
  localparam logic [7:0]  LeadMask    = 8'hE0;
  localparam logic [7:0]  LeadCode    = 8'hC0;
  localparam logic [10:0] CyrFirst    = 11'h410;
  localparam logic [10:0] CyrLast     = 11'h44F;
  localparam logic [10:0] CyrOffset   = 11'h350;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_CODE,
    OP_UNKNOWN
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [10:0] data;
    logic        last;
  } entry_t;

  function automatic logic [7:0] map_cp(input logic [10:0] cp);
    logic [10:0] diff;
    logic [7:0]  res;
    diff = cp - CyrOffset;
    case (cp)
      11'h406: res = 8'hB2;
      11'h456: res = 8'hB3;
      11'h407: res = 8'hAF;
      11'h457: res = 8'hBF;
      11'h404: res = 8'hAA;
      11'h454: res = 8'hBA;
      11'h490: res = 8'hA5;
      11'h491: res = 8'hB4;
      11'h402: res = 8'h80;
      11'h403: res = 8'h81;
      11'h453: res = 8'h83;
      11'h409: res = 8'h8A;
      11'h40A: res = 8'h8C;
      11'h40C: res = 8'h8D;
      11'h40B: res = 8'h8E;
      11'h40F: res = 8'h8F;
      11'h452: res = 8'h90;
      11'h459: res = 8'h9A;
      11'h45A: res = 8'h9C;
      11'h45C: res = 8'h9D;
      11'h45B: res = 8'h9E;
      11'h45F: res = 8'h9F;
      11'h40E: res = 8'hA1;
      11'h45E: res = 8'hA2;
      11'h408: res = 8'hA3;
      11'h0B5: res = 8'hB5;
      11'h458: res = 8'hBC;
      11'h405: res = 8'hBD;
      11'h455: res = 8'hBE;
      11'h42B: res = UnknownChar;
      11'h44B: res = UnknownChar;
      default: begin
        if (cp >= CyrFirst && cp <= CyrLast) begin
          res = diff[7:0];
        end else begin
          res = UnknownChar;
        end
      end
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// File: src/u2c_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_front
// Accepts input bytes, tracks a held two-byte lead and classifies each
// character into a queue entry.
// ----------------------------------------------------------------------------
module u2c_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire u2c_pkg::in_t  din,
  input  wire logic          q_full,
  output logic               q_wr,
  output u2c_pkg::entry_t    q_entry
);

  logic       lead_pending;
  logic [4:0] held_lead_bits;
  logic       accept;
  logic       is_lead;

  assign accept  = push && !q_full;
  assign is_lead = (din.in_byte & u2c_pkg::LeadMask) == u2c_pkg::LeadCode;

  always_comb begin
    q_entry.last = din.in_last;
    q_entry.data = {3'b000, din.in_byte};
    q_entry.op   = u2c_pkg::OP_UNKNOWN;
    q_wr         = accept;
    if (lead_pending) begin
      q_entry.op   = u2c_pkg::OP_CODE;
      q_entry.data = {held_lead_bits, din.in_byte[5:0]};
    end else if (!din.in_byte[7]) begin
      q_entry.op = u2c_pkg::OP_PASS;
    end else if (is_lead && !din.in_last) begin
      q_wr = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending   <= 1'b0;
      held_lead_bits <= '0;
    end else if (accept) begin
      if (lead_pending) begin
        lead_pending   <= 1'b0;
        held_lead_bits <= '0;
      end else if (din.in_byte[7] && is_lead && !din.in_last) begin
        lead_pending   <= 1'b1;
        held_lead_bits <= din.in_byte[4:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: src/u2c_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_queue
// Small register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module u2c_queue #(
  parameter int Depth = u2c_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire u2c_pkg::entry_t  wr_entry,
  output logic                  full,
  input  wire logic             rd,
  output logic                  empty,
  output u2c_pkg::entry_t       rd_entry
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u2c_pkg::entry_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full     = count == FullCnt;
  assign empty    = count == '0;
  assign do_wr    = wr && !full;
  assign do_rd    = rd && !empty;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/u2c_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2c_back
// Maps queued entries to CP1251 bytes and holds the result in an output
// register until it is popped.
// ----------------------------------------------------------------------------
module u2c_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire u2c_pkg::entry_t  q_entry,
  output logic                  q_rd,
  input  wire logic             pop,
  output logic                  empty,
  output u2c_pkg::out_t         dout
);

  logic          out_valid;
  u2c_pkg::out_t res;

  assign q_rd  = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    res.out_last = q_entry.last;
    case (q_entry.op)
      u2c_pkg::OP_PASS: res.out_byte = q_entry.data[7:0];
      u2c_pkg::OP_CODE: res.out_byte = u2c_pkg::map_cp(q_entry.data);
      default:          res.out_byte = u2c_pkg::UnknownChar;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      dout <= res;
    end
  end

endmodule
`default_nettype wire

// File: src/utf8_to_cp1251_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_cp1251_converter_core
// Path: a completing byte goes to the entry queue, then its result to the
//   output register once it is free; a held lead byte gives no result.
// Throughput: one byte per cycle while pop keeps up, set by the combinational
//   map in the back stage and the entry queue between front and back.
// Reset: synchronous rst clears the held lead, the queue and the output.
// ----------------------------------------------------------------------------
module utf8_to_cp1251_converter_core #(
  parameter int QueueDepth = u2c_pkg::QueueDepth
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire u2c_pkg::in_t   din,
  output logic                empty,
  input  wire logic           pop,
  output u2c_pkg::out_t       dout
);

  logic            q_wr;
  logic            q_rd;
  logic            q_empty;
  u2c_pkg::entry_t wr_entry;
  u2c_pkg::entry_t rd_entry;

  u2c_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din     (din),
    .q_full  (full),
    .q_wr    (q_wr),
    .q_entry (wr_entry)
  );

  u2c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_entry (wr_entry),
    .full     (full),
    .rd       (q_rd),
    .empty    (q_empty),
    .rd_entry (rd_entry)
  );

  u2c_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_entry (rd_entry),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .dout    (dout)
  );

endmodule
`default_nettype wire
